@@ hdl/ilp_pkg.sv @@
// Package for the integer literal parser: types, state record and character codes.
// Used by ilp_core and int_literal_parser_unit; depends on nothing.
`default_nettype none

package ilp_pkg;

    // Parser position within the literal.
    typedef enum logic [2:0] {
        PH_SIGN    = 3'd0,
        PH_PFX0    = 3'd1,
        PH_PFXX    = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_STOPPED = 3'd4,
        PH_ENDED   = 3'd5
    } phase_t;

    // Result status, also used as the sticky error code.
    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_INV = 2'd1,
        ST_OVF = 2'd2
    } status_t;

    // What stopped the literal before the end of the string.
    typedef enum logic [1:0] {
        STOP_NONE     = 2'd0,
        STOP_DOT      = 2'd1,
        STOP_PCT      = 2'd2,
        STOP_PCT_MORE = 2'd3
    } stop_t;

    // Complete parser state carried from one character to the next.
    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic        hex_mode;
        logic [31:0] accum;
        logic        skipping_zeros;
        logic        saw_zero;
        stop_t       stop_kind;
        status_t     error_code;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:          PH_SIGN,
        negative:       1'b0,
        hex_mode:       1'b0,
        accum:          32'd0,
        skipping_zeros: 1'b1,
        saw_zero:       1'b0,
        stop_kind:      STOP_NONE,
        error_code:     ST_OK
    };

    // Character codes.
    localparam logic [15:0] CH_NUL     = 16'h0000;
    localparam logic [15:0] CH_MINUS   = 16'h002D;
    localparam logic [15:0] CH_DOT     = 16'h002E;
    localparam logic [15:0] CH_PERCENT = 16'h0025;
    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_NINE    = 16'h0039;
    localparam logic [15:0] CH_UP_A    = 16'h0041;
    localparam logic [15:0] CH_UP_F    = 16'h0046;
    localparam logic [15:0] CH_UP_X    = 16'h0058;
    localparam logic [15:0] CH_LO_A    = 16'h0061;
    localparam logic [15:0] CH_LO_F    = 16'h0066;
    localparam logic [15:0] CH_LO_X    = 16'h0078;

    localparam logic [31:0] INT32_MAX_U = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN_U = 32'h8000_0000;

endpackage

`default_nettype wire

@@ hdl/ilp_core.sv @@
// Combinational step of the literal parser: next state for one character and
// the status and value for the end of the string. Depends on ilp_pkg.
`default_nettype none

module ilp_core
    import ilp_pkg::*;
(
    input  wire parse_state_t cur_state,
    input  wire logic [15:0]  char_code,
    output parse_state_t      next_state,
    output status_t           fin_status,
    output logic [31:0]       fin_value
);

    logic        do_digit;
    logic        is_dec;
    logic        is_up;
    logic        is_lo;
    logic        digit_ok;
    logic [3:0]  digit;
    logic [35:0] scaled;
    logic [35:0] sum;
    logic        saw_any;
    logic [31:0] neg_value;
    logic [31:0] signed_value;

    // Digit decode and multiply-add by the base; shifts and adds only.
    always_comb begin
        is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_up  = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
        is_lo  = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
        digit  = 4'd0;
        if (is_dec) begin
            digit = char_code[3:0];
        end else if (is_up || is_lo) begin
            digit = char_code[3:0] + 4'd9;
        end
        digit_ok = cur_state.hex_mode ? (is_dec || is_up || is_lo) : is_dec;
        if (cur_state.hex_mode) begin
            scaled = {cur_state.accum, 4'd0};
        end else begin
            scaled = {1'b0, cur_state.accum, 3'd0} + {3'd0, cur_state.accum, 1'b0};
        end
        sum = scaled + {32'd0, digit};
    end

    // Next state for one character.
    always_comb begin
        next_state = cur_state;
        do_digit   = 1'b0;
        if (cur_state.error_code == ST_OK) begin
            unique case (cur_state.phase)
                PH_SIGN: begin
                    if (char_code == CH_MINUS) begin
                        next_state.negative = 1'b1;
                        next_state.phase    = PH_PFX0;
                    end else if (char_code == CH_ZERO) begin
                        next_state.phase = PH_PFXX;
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                PH_PFX0: begin
                    if (char_code == CH_ZERO) begin
                        next_state.phase = PH_PFXX;
                    end else begin
                        do_digit = 1'b1;
                    end
                end
                PH_PFXX: begin
                    if (char_code == CH_LO_X || char_code == CH_UP_X) begin
                        next_state.hex_mode = 1'b1;
                        next_state.phase    = PH_DIGITS;
                    end else begin
                        next_state.saw_zero = 1'b1;
                        do_digit            = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                PH_STOPPED: begin
                    if (cur_state.stop_kind == STOP_PCT && char_code != CH_NUL) begin
                        next_state.stop_kind = STOP_PCT_MORE;
                    end
                    next_state.phase = PH_ENDED;
                end
                default: begin
                end
            endcase
        end

        // Digit position: terminators, leading zeros, then the digit itself.
        if (do_digit) begin
            next_state.phase = PH_DIGITS;
            if (char_code == CH_NUL) begin
                next_state.phase = PH_ENDED;
            end else if (char_code == CH_DOT) begin
                next_state.stop_kind = STOP_DOT;
                next_state.phase     = PH_STOPPED;
            end else if (char_code == CH_PERCENT) begin
                next_state.stop_kind = STOP_PCT;
                next_state.phase     = PH_STOPPED;
            end else if (cur_state.skipping_zeros && char_code == CH_ZERO) begin
                next_state.saw_zero = 1'b1;
            end else begin
                next_state.skipping_zeros = 1'b0;
                if (!digit_ok) begin
                    next_state.error_code = ST_INV;
                end else if (sum[35:32] != 4'd0) begin
                    next_state.error_code = ST_OVF;
                end else begin
                    next_state.accum = sum[31:0];
                end
            end
        end
    end

    // Result at the end of the string: range checks before the stop kind.
    always_comb begin
        saw_any      = cur_state.saw_zero || (cur_state.phase == PH_PFXX);
        neg_value    = 32'd0 - cur_state.accum;
        signed_value = cur_state.negative ? neg_value : cur_state.accum;
        fin_status   = ST_OK;
        fin_value    = 32'd0;
        if (cur_state.error_code != ST_OK) begin
            fin_status = cur_state.error_code;
        end else if (cur_state.accum == 32'd0 && !saw_any) begin
            fin_status = ST_INV;
        end else if (cur_state.negative && !cur_state.hex_mode
                     && cur_state.accum > INT32_MIN_U) begin
            fin_status = ST_OVF;
        end else if (cur_state.negative && cur_state.hex_mode
                     && cur_state.accum == INT32_MIN_U) begin
            fin_status = ST_OVF;
        end else if (!cur_state.negative && !cur_state.hex_mode
                     && cur_state.accum > INT32_MAX_U) begin
            fin_status = ST_OVF;
        end else if (cur_state.stop_kind == STOP_NONE) begin
            fin_value = signed_value;
        end else if (cur_state.stop_kind == STOP_PCT) begin
            fin_value = {16'd0, signed_value[15:0]};
        end else begin
            fin_status = ST_INV;
        end
    end

endmodule

`default_nettype wire

@@ hdl/int_literal_parser_unit.sv @@
// Top level of the integer literal parser: input register, parser state and
// result register around ilp_core. Depends on ilp_pkg and ilp_core.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_char_code[15:0], s_is_end
//   m_       out        m_valid / m_ready    m_status[1:0], m_value[31:0] signed
//
// One transaction can be accepted every cycle while s_ready is high. It is held in
// the input register and updates the parser state in a single pass as it leaves it.
// An end transaction loads the result register at that same edge, so m_valid rises
// as the end leaves the input register, and the parser returns to its reset state.
// An end transaction waits in the input register while an earlier result is still
// unaccepted; s_ready then drops and later transactions stall behind it.
// Reset (aresetn low, synchronous) empties both registers and clears the state.
`default_nettype none

module int_literal_parser_unit
    import ilp_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [15:0]        s_char_code,
    input  wire                s_is_end,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_value
);

    logic         in_valid_reg;
    logic [15:0]  in_char_reg;
    logic         in_end_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    status_t      out_status_reg;
    logic [31:0]  out_value_reg;
    status_t      fin_status;
    logic [31:0]  fin_value;
    logic         advance;
    logic         load_out;

    ilp_core u_core (
        .cur_state  (state_reg),
        .char_code  (in_char_reg),
        .next_state (state_next),
        .fin_status (fin_status),
        .fin_value  (fin_value)
    );

    // The held transaction moves on unless it is an end with the result still waiting.
    assign advance  = in_valid_reg && (!in_end_reg || !out_valid_reg || m_ready);
    assign load_out = advance && in_end_reg;
    assign s_ready  = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_code;
            in_end_reg  <= s_is_end;
        end
    end

    // Parser state: updated per character, cleared after an end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= in_end_reg ? STATE_RESET : state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_status_reg <= fin_status;
            out_value_reg  <= fin_value;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_value  = out_value_reg;

endmodule

`default_nettype wire
